### design/mlrq_pkg.sv
// package: types, constants and codes for the multilevel linked ready queues
package mlrq_pkg;
	localparam int SLOTS_DEF = 64;
	localparam int LEVELS_DEF = 4;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_QUEUED = 2'd1;
	localparam logic [1:0] ST_UNQUEUED = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FIX,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic do_link;
		logic do_fix;
	} cmd_t;

	typedef struct packed {
		logic reject;
	} sts_t;
endpackage

### design/mlrq_ram.sv
// generic single-port ram with registered read
module mlrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### design/mlrq_ctrl.sv
// controller state machine for the ready queue operations
module mlrq_ctrl import mlrq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_fire,
	input  sts_t sts,
	output logic busy,
	output logic out_valid,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.do_link = 1'b1;
				if (sts.reject) begin
					state_d = S_OUT;
				end else begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				cmd.do_fix = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### design/mlrq_dp.sv
// datapath: per-slot tables, level registers and link updates
module mlrq_dp import mlrq_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int LEVELS = LEVELS_DEF,
	localparam int SW = $clog2(SLOTS),
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1,
	localparam int PW = $clog2(SLOTS + 1),
	localparam int RW = LW + 35
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        in_kind,
	input  logic [5:0]  in_slot,
	input  logic [1:0]  in_level,
	input  logic        in_stamp,
	input  logic        in_rear,
	input  logic [31:0] in_now,
	output sts_t        sts,
	output logic [1:0]  status,
	output logic [1:0]  affected_level,
	output logic [6:0]  level_count,
	output logic        head_valid,
	output logic [5:0]  head_slot,
	output logic [5:0]  tail_slot,
	output logic [31:0] slot_entry_time,
	output logic        slot_drop_mark,
	output logic        slot_rear_mark
);
	localparam logic [PW-1:0] NIL = PW'(SLOTS);

	// index reduction tables
	logic [SW-1:0]    slot_map [64];
	logic [LW-1:0]    lvl_map [4];
	logic [SW-1:0]    slot_in;
	logic [LW-1:0]    lvl_in;

	// one written mark per slot covers the link and record rams
	logic [SLOTS-1:0] written_q;
	logic [PW-1:0]    head_q [LEVELS];
	logic [PW-1:0]    tail_q [LEVELS];
	logic [PW-1:0]    size_q [LEVELS];

	logic             kind_q, stamp_q, rear_q;
	logic [SW-1:0]    s_q;
	logic [LW-1:0]    lv_q;
	logic [31:0]      now_q;
	logic [1:0]       status_q;
	logic [31:0]      time_o_q;
	logic             drop_o_q, rear_o_q;

	// neighbour patches for the fix step
	logic             fn_we, fp_we, fn_we_q, fp_we_q;
	logic [SW-1:0]    fn_a, fp_a, fn_a_q, fp_a_q;
	logic [PW-1:0]    fn_v, fp_v, fn_v_q, fp_v_q;

	logic             n_we, p_we, r_we;
	logic [SW-1:0]    base_addr, n_addr, p_addr;
	logic [PW-1:0]    n_wd, p_wd, n_rd, p_rd;
	logic [RW-1:0]    r_wd, r_rd, rec_old;

	logic             vld, is_rem, reject;
	logic [PW-1:0]    nx, pv;
	logic [LW-1:0]    old_lvl, lv_eff;
	logic             old_q, old_drop, old_rear;
	logic [31:0]      old_time, new_time;
	logic             new_drop, new_rear;
	logic [PW-1:0]    h_cur, t_cur, sz_cur;
	logic [PW-1:0]    size_o, head_o, tail_o;

	always_comb begin
		for (int i = 0; i < 64; i++) slot_map[i] = SW'(i % SLOTS);
		for (int i = 0; i < 4; i++) lvl_map[i] = LW'(i % LEVELS);
	end
	assign slot_in = slot_map[in_slot];
	assign lvl_in = lvl_map[in_level];

	// record of slot s as read, unwritten entries read as reset values
	assign vld = written_q[s_q];
	assign nx = vld ? n_rd : NIL;
	assign pv = vld ? p_rd : NIL;
	assign rec_old = vld ? r_rd : '0;
	assign {old_time, old_rear, old_drop, old_q, old_lvl} = rec_old;

	assign is_rem = (kind_q == KIND_REMOVE);
	assign lv_eff = is_rem ? old_lvl : lv_q;
	assign reject = is_rem ? !old_q : old_q;
	assign sts.reject = reject;

	assign h_cur = head_q[lv_eff];
	assign t_cur = tail_q[lv_eff];
	assign sz_cur = size_q[lv_eff];

	assign new_time = (!is_rem && stamp_q) ? now_q : old_time;
	assign new_drop = is_rem | old_drop;
	assign new_rear = is_rem | old_rear;
	assign r_wd = {new_time, new_rear, new_drop, !is_rem, lv_eff};

	assign base_addr = cmd.load ? slot_in : s_q;

	always_comb begin
		fn_we = 1'b0; fp_we = 1'b0;
		fn_a = '0; fp_a = '0;
		fn_v = NIL; fp_v = NIL;
		if (!reject) begin
			if (!is_rem) begin
				if (rear_q) begin
					fn_we = (t_cur < NIL); fn_a = t_cur[SW-1:0]; fn_v = PW'(s_q);
				end else begin
					fp_we = (h_cur < NIL); fp_a = h_cur[SW-1:0]; fp_v = PW'(s_q);
				end
			end else begin
				fn_we = (pv < NIL); fn_a = pv[SW-1:0]; fn_v = nx;
				fp_we = (nx < NIL); fp_a = nx[SW-1:0]; fp_v = pv;
			end
		end
	end

	always_comb begin
		n_we = 1'b0; p_we = 1'b0; r_we = 1'b0;
		n_addr = base_addr; p_addr = base_addr;
		n_wd = NIL; p_wd = NIL;
		if (cmd.do_link && !reject) begin
			n_we = 1'b1; p_we = 1'b1; r_we = 1'b1;
			if (!is_rem) begin
				if (rear_q) begin
					p_wd = t_cur;
				end else begin
					n_wd = h_cur;
				end
			end
		end
		if (cmd.do_fix) begin
			n_we = fn_we_q; n_addr = fn_a_q; n_wd = fn_v_q;
			p_we = fp_we_q; p_addr = fp_a_q; p_wd = fp_v_q;
		end
	end

	mlrq_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_next (
		.clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd));
	mlrq_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_prev (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));
	mlrq_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_rec (
		.clk(clk), .we(r_we), .addr(base_addr), .wdata(r_wd), .rdata(r_rd));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind; stamp_q <= in_stamp; rear_q <= in_rear;
			s_q <= slot_in; lv_q <= lvl_in; now_q <= in_now;
		end
		if (cmd.do_link) begin
			lv_q <= lv_eff;
			status_q <= reject ? (is_rem ? ST_UNQUEUED : ST_QUEUED) : ST_DONE;
			time_o_q <= reject ? old_time : new_time;
			drop_o_q <= reject ? old_drop : new_drop;
			rear_o_q <= reject ? old_rear : new_rear;
		end
	end

	// level registers, written marks and patch registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			fn_we_q <= 1'b0; fp_we_q <= 1'b0;
			fn_a_q <= '0; fp_a_q <= '0;
			fn_v_q <= NIL; fp_v_q <= NIL;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= NIL; tail_q[i] <= NIL; size_q[i] <= '0;
			end
		end else if (cmd.do_link) begin
			fn_we_q <= fn_we; fp_we_q <= fp_we;
			fn_a_q <= fn_a; fp_a_q <= fp_a;
			fn_v_q <= fn_v; fp_v_q <= fp_v;
			if (!reject) begin
				written_q[s_q] <= 1'b1;
				if (!is_rem) begin
					size_q[lv_eff] <= sz_cur + PW'(1);
					if (rear_q) begin
						if (!(t_cur < NIL)) head_q[lv_eff] <= PW'(s_q);
						tail_q[lv_eff] <= PW'(s_q);
					end else begin
						if (!(h_cur < NIL)) tail_q[lv_eff] <= PW'(s_q);
						head_q[lv_eff] <= PW'(s_q);
					end
				end else begin
					if (sz_cur <= PW'(1)) begin
						size_q[lv_eff] <= '0;
						head_q[lv_eff] <= NIL; tail_q[lv_eff] <= NIL;
					end else begin
						size_q[lv_eff] <= sz_cur - PW'(1);
						if (!(pv < NIL)) head_q[lv_eff] <= nx;
						if (!(nx < NIL)) tail_q[lv_eff] <= pv;
					end
				end
			end
		end
	end

	// result
	assign size_o = size_q[lv_q];
	assign head_o = head_q[lv_q];
	assign tail_o = tail_q[lv_q];
	assign status = status_q;
	assign affected_level = 2'(lv_q);
	assign level_count = 7'(size_o);
	assign head_valid = (size_o != '0) && (head_o < NIL);
	assign head_slot = head_valid ? 6'(head_o) : 6'd0;
	assign tail_slot = (head_valid && tail_o < NIL) ? 6'(tail_o) : 6'd0;
	assign slot_entry_time = time_o_q;
	assign slot_drop_mark = drop_o_q;
	assign slot_rear_mark = rear_o_q;
endmodule

### design/multilevel_linked_ready_queues.sv
// top level: multilevel linked ready queues over a fixed slot pool
// an operation reads the slot's record, links it and patches its neighbours before the result
// is valid; a rejected beat skips the patch; one operation at a time: a new beat is taken only
// once the result has been taken at the output
// reset: asynchronous, empties all levels and makes every slot read as unwritten
module multilevel_linked_ready_queues import mlrq_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // slot, level, stamp_time, at_rear, now
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // status, affected_level, level_count, head_valid,
	                              // head_slot, tail_slot, slot_entry_time,
	                              // slot_drop_mark, slot_rear_mark
);
	cmd_t cmd;
	sts_t sts;
	logic busy;

	logic [1:0]  status, affected_level;
	logic [6:0]  level_count;
	logic        head_valid, slot_drop_mark, slot_rear_mark;
	logic [5:0]  head_slot, tail_slot;
	logic [31:0] slot_entry_time;

	// a new beat is taken only while the controller is idle
	assign s_tready = !busy;

	mlrq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.out_fire(m_tvalid && m_tready), .sts(sts), .busy(busy),
		.out_valid(m_tvalid), .cmd(cmd));

	mlrq_dp #(.SLOTS(SLOTS), .LEVELS(LEVELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_kind(s_tuser), .in_slot(s_tdata[5:0]), .in_level(s_tdata[7:6]),
		.in_stamp(s_tdata[8]), .in_rear(s_tdata[9]), .in_now(s_tdata[41:10]),
		.sts(sts), .status(status), .affected_level(affected_level),
		.level_count(level_count), .head_valid(head_valid), .head_slot(head_slot),
		.tail_slot(tail_slot), .slot_entry_time(slot_entry_time),
		.slot_drop_mark(slot_drop_mark), .slot_rear_mark(slot_rear_mark));

	// result fields packed from bit 0 up, padded to whole bytes
	assign m_tdata = {6'd0, slot_rear_mark, slot_drop_mark, slot_entry_time,
		tail_slot, head_slot, head_valid, level_count, affected_level, status};
endmodule

### tb/sv/tb_top.sv
// testbench: random and directed ready-queue operations checked against a local queue predictor
`timescale 1ns / 1ps

module tb_top import mlrq_pkg::*; ();
	localparam int NSLOT = 64;
	localparam int NLEVEL = 4;
	localparam int NIL = NSLOT;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic        rear_mark;
		logic        drop_mark;
		logic [31:0] entry_time;
		logic [5:0]  tail_slot;
		logic [5:0]  head_slot;
		logic        head_valid;
		logic [6:0]  level_count;
		logic [1:0]  level;
		logic [1:0]  status;
	} queue_report_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	// predictor copy of the link tables
	int          nxt [NSLOT];
	int          prv [NSLOT];
	logic [1:0]  lvl_of [NSLOT];
	bit          queued [NSLOT];
	logic [31:0] stamp_of [NSLOT];
	bit          drop_of [NSLOT];
	bit          rear_of [NSLOT];
	int          lhead [NLEVEL];
	int          ltail [NLEVEL];
	int          lsize [NLEVEL];

	queue_report_t expected_reports [$];
	int  mismatches = 0;
	int  idle_cycles = 0;
	bit  quiet = 0;
	bit  timed_out = 0;

	multilevel_linked_ready_queues dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic clear_queues();
		for (int i = 0; i < NSLOT; i++) begin
			nxt[i] = NIL; prv[i] = NIL; lvl_of[i] = '0; queued[i] = 1'b0;
			stamp_of[i] = '0; drop_of[i] = 1'b0; rear_of[i] = 1'b0;
		end
		for (int l = 0; l < NLEVEL; l++) begin
			lhead[l] = NIL; ltail[l] = NIL; lsize[l] = 0;
		end
	endtask

	// apply one operation to the queue copy and return what the block should report
	function automatic queue_report_t apply_op(logic kind, logic [5:0] s, logic [1:0] lv_in,
			logic stamp, logic rear, logic [31:0] now);
		queue_report_t r;
		int lv;
		int p;
		int n;
		r = '0;
		r.status = ST_DONE;
		lv = int'(lv_in);
		if (kind == KIND_INSERT) begin
			if (queued[s]) begin
				r.status = ST_QUEUED;
			end else begin
				if (rear) begin
					nxt[s] = NIL;
					prv[s] = ltail[lv];
					if (ltail[lv] != NIL) nxt[ltail[lv]] = int'(s);
					else lhead[lv] = int'(s);
					ltail[lv] = int'(s);
				end else begin
					prv[s] = NIL;
					nxt[s] = lhead[lv];
					if (lhead[lv] != NIL) prv[lhead[lv]] = int'(s);
					else ltail[lv] = int'(s);
					lhead[lv] = int'(s);
				end
				lsize[lv]++;
				if (stamp) stamp_of[s] = now;
				lvl_of[s] = 2'(lv);
				queued[s] = 1'b1;
			end
		end else begin
			lv = int'(lvl_of[s]);
			if (!queued[s]) begin
				r.status = ST_UNQUEUED;
			end else begin
				p = prv[s];
				n = nxt[s];
				if (p != NIL) nxt[p] = n;
				else lhead[lv] = n;
				if (n != NIL) prv[n] = p;
				else ltail[lv] = p;
				prv[s] = NIL;
				nxt[s] = NIL;
				if (lsize[lv] > 0) lsize[lv]--;
				if (lsize[lv] == 0) begin
					lhead[lv] = NIL; ltail[lv] = NIL;
				end
				queued[s] = 1'b0; drop_of[s] = 1'b1; rear_of[s] = 1'b1;
			end
		end
		r.level = 2'(lv);
		r.level_count = 7'(lsize[lv]);
		r.head_valid = (lsize[lv] != 0) && (lhead[lv] != NIL);
		r.head_slot = r.head_valid ? 6'(lhead[lv]) : 6'd0;
		r.tail_slot = (r.head_valid && ltail[lv] != NIL) ? 6'(ltail[lv]) : 6'd0;
		r.entry_time = stamp_of[s];
		r.drop_mark = drop_of[s];
		r.rear_mark = rear_of[s];
		return r;
	endfunction

	// one beat: drive at the falling edge, wait for the handshake at a rising edge
	task automatic send_op(logic kind, logic [5:0] s, logic [1:0] lv, logic stamp,
			logic rear, logic [31:0] now);
		if (!quiet && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'd0, now, rear, stamp, lv, s};
		do @(posedge clk); while (!s_tready);
		expected_reports.push_back(apply_op(kind, s, lv, stamp, rear, now));
		@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		queue_report_t got;
		queue_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[57:0];
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
			end else begin
				want = expected_reports.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 21);
	end

	// watchdog on stalled progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		send_op(KIND_REMOVE, 6'd0, 2'd0, 1'b0, 1'b0, 32'd0);          // remove never queued
		send_op(KIND_INSERT, 6'd0, 2'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_op(KIND_INSERT, 6'd63, 2'd0, 1'b1, 1'b1, 32'd5);
		send_op(KIND_INSERT, 6'd1, 2'd0, 1'b0, 1'b0, 32'd9);          // front, no stamp
		send_op(KIND_INSERT, 6'd0, 2'd3, 1'b1, 1'b0, 32'd7);          // already queued
		send_op(KIND_INSERT, 6'd2, 2'd3, 1'b1, 1'b0, 32'h8000_0000);
		send_op(KIND_INSERT, 6'd3, 2'd3, 1'b1, 1'b1, 32'h1234_5678);
		send_op(KIND_INSERT, 6'd4, 2'd2, 1'b0, 1'b1, 32'd0);
		send_op(KIND_INSERT, 6'd5, 2'd1, 1'b1, 1'b0, 32'h5555_AAAA);
		send_op(KIND_REMOVE, 6'd0, 2'd3, 1'b1, 1'b1, 32'd1);          // middle of level 0
		send_op(KIND_REMOVE, 6'd1, 2'd0, 1'b0, 1'b0, 32'd0);          // head
		send_op(KIND_REMOVE, 6'd63, 2'd0, 1'b0, 1'b0, 32'd0);         // last, empties level
		send_op(KIND_REMOVE, 6'd63, 2'd2, 1'b0, 1'b0, 32'd0);         // remove again
		send_op(KIND_INSERT, 6'd63, 2'd1, 1'b0, 1'b0, 32'd3);         // marks kept
		send_op(KIND_REMOVE, 6'd3, 2'd0, 1'b0, 1'b0, 32'd0);          // tail
		send_op(KIND_REMOVE, 6'd2, 2'd0, 1'b0, 1'b0, 32'd0);
		send_op(KIND_REMOVE, 6'd4, 2'd0, 1'b0, 1'b0, 32'd0);
		send_op(KIND_REMOVE, 6'd5, 2'd0, 1'b0, 1'b0, 32'd0);
		send_op(KIND_REMOVE, 6'd63, 2'd0, 1'b0, 1'b0, 32'd0);
	endtask

	// random mix, biased towards useful inserts and removes
	task automatic test_random(int count, int slot_span);
		logic [5:0] s;
		logic k;
		for (int i = 0; i < count; i++) begin
			s = 6'($urandom_range(slot_span - 1));
			if ($urandom_range(9) == 0) k = 1'($urandom_range(1));
			else k = queued[s] ? KIND_REMOVE : KIND_INSERT;
			if ($urandom_range(2) == 0) k = 1'($urandom_range(1));
			send_op(k, s, 2'($urandom_range(3)), 1'($urandom_range(1)),
				1'($urandom_range(1)), $urandom());
		end
	endtask

	// fill every slot then drain in random order
	task automatic test_fill_drain();
		for (int i = 0; i < NSLOT; i++)
			send_op(KIND_INSERT, 6'(i), 2'($urandom_range(3)), 1'b1,
				1'($urandom_range(1)), $urandom());
		for (int i = 0; i < NSLOT; i++)
			send_op(KIND_REMOVE, 6'($urandom_range(NSLOT - 1)), 2'd0, 1'b0, 1'b0, 32'd0);
		for (int i = 0; i < NSLOT; i++)
			if (queued[i]) send_op(KIND_REMOVE, 6'(i), 2'd0, 1'b0, 1'b0, 32'd0);
	endtask

	initial begin
		int waited;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		clear_queues();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(600, 8);
		quiet = 1;
		test_random(300, 64);
		quiet = 0;
		test_fill_drain();
		test_random(800, 64);
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_reports.size() != 0 && waited < WATCHDOG_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_reports.size() != 0) timed_out = 1;
		repeat (20) @(posedge clk);
		if (mismatches == 0 && !timed_out && expected_reports.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
